>>> sv/tspn_pkg.sv
// Shared types, constants and round functions of the toy SPN block cipher.
package tspn_pkg;

    localparam int BLOCK_W        = 16;
    localparam int KEY_COUNT      = 4;
    localparam int KEY_IDX_W      = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int ROUNDS_DEFAULT = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_3 = 3'd3;

    // Commands
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [KEY_COUNT-1:0][BLOCK_W-1:0] key_bank_t;

    typedef struct packed {
        logic   vld;
        logic   cmd;
        block_t data;
    } stage_t;

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'h5, 4'h2, 4'h6, 4'h8, 4'h1, 4'hd, 4'h7, 4'he,
        4'h4, 4'hf, 4'hc, 4'ha, 4'hb, 4'h3, 4'h0, 4'h9
    };

    localparam logic [3:0] SBOX_INV [16] = '{
        4'he, 4'h4, 4'h1, 4'hd, 4'h8, 4'h0, 4'h2, 4'h6,
        4'h3, 4'hf, 4'hb, 4'hc, 4'ha, 4'h5, 4'h7, 4'h9
    };

    localparam logic [3:0] BIT_SRC [16] = '{
        4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
        4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
    };

    function automatic block_t subst_fwd(input block_t x);
        block_t y;
        y = '0;
        for (int n = 0; n < 4; n++) begin
            y[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
        end
        return y;
    endfunction

    function automatic block_t subst_inv(input block_t x);
        block_t y;
        y = '0;
        for (int n = 0; n < 4; n++) begin
            y[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
        end
        return y;
    endfunction

    // Nibble transpose; its own inverse
    function automatic block_t permute(input block_t x);
        block_t y;
        y = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            y[i] = x[BIT_SRC[i]];
        end
        return y;
    endfunction

endpackage

>>> sv/tspn_round.sv
// One registered round stage of the cipher, serving both directions.
module tspn_round
    import tspn_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT,
    parameter int STAGE  = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  stage_t    stage_in,
    input  key_bank_t keys,
    output stage_t    stage_out
);

    localparam bit FIRST = (STAGE == 0);
    localparam bit LAST  = (STAGE == ROUNDS - 1);

    localparam logic [KEY_IDX_W-1:0] ENC_KEY   = KEY_IDX_W'(STAGE % KEY_COUNT);
    localparam logic [KEY_IDX_W-1:0] ENC_WHITE = KEY_IDX_W'(ROUNDS % KEY_COUNT);
    localparam logic [KEY_IDX_W-1:0] DEC_WHITE = KEY_IDX_W'(ROUNDS % KEY_COUNT);
    localparam logic [KEY_IDX_W-1:0] DEC_KEY   =
        KEY_IDX_W'((ROUNDS - 1 - STAGE) % KEY_COUNT);

    logic   vld_reg;
    logic   cmd_reg;
    block_t data_reg;
    block_t enc_sub;
    block_t enc_res;
    block_t dec_pre;
    block_t dec_res;
    block_t data_next;

    always_comb
    begin
        enc_sub = subst_fwd(stage_in.data ^ keys[ENC_KEY]);
        enc_res = LAST ? (enc_sub ^ keys[ENC_WHITE]) : permute(enc_sub);

        // first decrypt stage strips the whitening key, later ones undo the permutation
        dec_pre = FIRST ? (stage_in.data ^ keys[DEC_WHITE]) : permute(stage_in.data);
        dec_res = subst_inv(dec_pre) ^ keys[DEC_KEY];

        data_next = (stage_in.cmd == CMD_DECRYPT) ? dec_res : enc_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= stage_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= stage_in.cmd;
        data_reg <= data_next;
    end

    assign stage_out = '{vld: vld_reg, cmd: cmd_reg, data: data_reg};

endmodule

>>> sv/toy_spn_block_cipher.sv
// Top level of the pipelined toy SPN block cipher.
//
//  channel   signals                         transfer when
//  --------  ------------------------------  --------------------------
//  input     start, busy, command, block_in  start high and busy low
//  result    done, block_out                 every cycle done is high
//  config    cfg_we, cfg_index, cfg_data     every cycle cfg_we is high
//
// One block enters per cycle; busy stays low. A block passes through one
// input register, then one register stage per cipher round, before it
// comes out. Results appear in order and are shown for one cycle.
// Reset clears the valid bits and the round keys.
module toy_spn_block_cipher
    import tspn_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 command,
    input  logic [BLOCK_W-1:0]   block_in,
    output logic                 done,
    output logic [BLOCK_W-1:0]   block_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BLOCK_W-1:0]   cfg_data
);

    key_bank_t key_reg;
    logic      in_vld_reg;
    logic      in_cmd_reg;
    block_t    in_data_reg;
    stage_t    pipe [ROUNDS+1];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
            // drop writes beyond the key bank
            if (cfg_we && (cfg_index <= REG_ROUND_KEY_3))
            begin
                key_reg[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_cmd_reg  <= command;
        in_data_reg <= block_in;
    end

    assign pipe[0] = '{vld: in_vld_reg, cmd: in_cmd_reg, data: in_data_reg};

    for (genvar j = 0; j < ROUNDS; j++)
    begin : g_round
        tspn_round #(
            .ROUNDS (ROUNDS),
            .STAGE  (j)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (pipe[j]),
            .keys      (key_reg),
            .stage_out (pipe[j+1])
        );
    end

    assign done      = pipe[ROUNDS].vld;
    assign block_out = pipe[ROUNDS].data;

endmodule

>>> sv/tspn_checker.sv
// Port-level checker for the toy SPN block cipher, bound to the top level.
module tspn_checker
    import tspn_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    localparam int LATENCY = ROUNDS + 1;

    logic xfer;
    assign xfer = start && !busy;

    // every transferred block comes out after the input register and all round stages
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> ##LATENCY done)
        else $error("block transferred in but no result after pipeline latency");

    // no result without a matching input transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(xfer, LATENCY))
        else $error("result strobe without a transfer in");

    // the pipeline takes a block every cycle
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("busy raised while start high");

    // no result strobe in the first cycle after reset is released
    a_reset_clears_done: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result strobe right after reset");

endmodule

bind toy_spn_block_cipher tspn_checker #(.ROUNDS(ROUNDS)) u_tspn_checker (.*);
